[hw/rtl/lbps_pkg.sv]
// ----------------------------------------------------------------------------
// lbps_pkg
// Shared types and constants for the LED blink pattern sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lbps_pkg;

    localparam int NUM_LEDS = 4;

    localparam logic [NUM_LEDS-1:0] LED_ALL_ON  = 4'h0;
    localparam logic [NUM_LEDS-1:0] LED_ALL_OFF = 4'hF;
    localparam logic [1:0]          CLEAR_BLINKS = 2'd3;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_CLEAR   = 3'd1,
        MODE_DIGIT   = 3'd2,
        MODE_MARQUEE = 3'd3,
        MODE_LOW     = 3'd4
    } mode_t;

    typedef struct packed {
        logic       func;
        logic [2:0] start_mode;
        logic [3:0] count_units;
        logic [3:0] count_tens;
        logic [3:0] count_hundreds;
        logic [3:0] count_thousands;
        logic [7:0] count_low;
    } item_t;

    typedef struct packed {
        logic [NUM_LEDS-1:0] led_n;
        logic                led_write;
        logic                timer_stop;
        mode_t               mode_now;
    } result_t;

endpackage

`default_nettype wire

[hw/rtl/lbps_in_reg.sv]
// ----------------------------------------------------------------------------
// lbps_in_reg
// Input register stage. Holds one beat until the step logic consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lbps_in_reg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output      logic           in_stall,
    input  wire lbps_pkg::item_t in_item,
    input  wire logic           take,
    output      logic           item_valid,
    output      lbps_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    logic            load;
    lbps_pkg::item_t item_reg;

    // The stage refills in the same cycle that it hands its beat on.
    assign in_stall = valid_reg && !take;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

[hw/rtl/lbps_core.sv]
// ----------------------------------------------------------------------------
// lbps_core
// Sequencer state and the single-step update for one start or tick beat.
// ----------------------------------------------------------------------------
`default_nettype none

module lbps_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fire,
    input  wire lbps_pkg::item_t item,
    output      lbps_pkg::result_t res
);

    lbps_pkg::mode_t mode_reg;
    lbps_pkg::mode_t mode_next;
    logic [1:0]      clear_done_reg;
    logic [1:0]      clear_done_next;
    logic            clear_on_reg;
    logic            clear_on_next;
    logic [3:0]      digit_on_reg;
    logic [3:0]      digit_on_next;
    logic [3:0]      digit_left_reg  [lbps_pkg::NUM_LEDS];
    logic [3:0]      digit_left_next [lbps_pkg::NUM_LEDS];
    logic [1:0]      mq_index_reg;
    logic [1:0]      mq_index_next;
    logic            mq_fwd_reg;
    logic            mq_fwd_next;
    logic            low_on_reg;
    logic            low_on_next;
    logic [7:0]      low_left_reg;
    logic [7:0]      low_left_next;

    logic [3:0]      led;
    logic            wr;
    logic            stop;
    logic            digits_done;
    logic            found;

    // Mode register next state.
    always_comb
    begin
        mode_next = mode_reg;
        if (item.func == lbps_pkg::FUNC_START)
        begin
            unique case (item.start_mode)
                lbps_pkg::MODE_CLEAR:   mode_next = lbps_pkg::MODE_CLEAR;
                lbps_pkg::MODE_DIGIT:   mode_next = lbps_pkg::MODE_DIGIT;
                lbps_pkg::MODE_MARQUEE: mode_next = lbps_pkg::MODE_MARQUEE;
                lbps_pkg::MODE_LOW:     mode_next = lbps_pkg::MODE_LOW;
                default:                mode_next = lbps_pkg::MODE_IDLE;
            endcase
        end
        else
        begin
            unique case (mode_reg)
                lbps_pkg::MODE_CLEAR:
                begin
                    if (clear_done_reg == lbps_pkg::CLEAR_BLINKS)
                    begin
                        mode_next = lbps_pkg::MODE_IDLE;
                    end
                end
                lbps_pkg::MODE_DIGIT:
                begin
                    if (digits_done)
                    begin
                        mode_next = lbps_pkg::MODE_IDLE;
                    end
                end
                lbps_pkg::MODE_MARQUEE:
                begin
                    mode_next = lbps_pkg::MODE_MARQUEE;
                end
                lbps_pkg::MODE_LOW:
                begin
                    if (low_left_reg == 8'd0)
                    begin
                        mode_next = lbps_pkg::MODE_IDLE;
                    end
                end
                default:
                begin
                    mode_next = lbps_pkg::MODE_IDLE;
                end
            endcase
        end
    end

    // Counters, phases and the LED pattern for this step.
    always_comb
    begin
        clear_done_next = clear_done_reg;
        clear_on_next   = clear_on_reg;
        digit_on_next   = digit_on_reg;
        digit_left_next = digit_left_reg;
        mq_index_next   = mq_index_reg;
        mq_fwd_next     = mq_fwd_reg;
        low_on_next     = low_on_reg;
        low_left_next   = low_left_reg;
        led             = lbps_pkg::LED_ALL_OFF;
        wr              = 1'b0;
        stop            = 1'b0;
        found           = 1'b0;

        if (item.func == lbps_pkg::FUNC_START)
        begin
            digit_left_next[0] = item.count_units;
            digit_left_next[1] = item.count_tens;
            digit_left_next[2] = item.count_hundreds;
            digit_left_next[3] = item.count_thousands;
            low_left_next      = item.count_low;
        end
        else
        begin
            case (mode_reg)
                lbps_pkg::MODE_CLEAR:
                begin
                    wr = 1'b1;
                    if (clear_done_reg != lbps_pkg::CLEAR_BLINKS)
                    begin
                        if (!clear_on_reg)
                        begin
                            led           = lbps_pkg::LED_ALL_ON;
                            clear_on_next = 1'b1;
                        end
                        else
                        begin
                            clear_on_next   = 1'b0;
                            clear_done_next = clear_done_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        clear_done_next = 2'd0;
                    end
                end
                lbps_pkg::MODE_DIGIT:
                begin
                    // The lowest LED with blinks left takes this step.
                    for (int i = 0; i < lbps_pkg::NUM_LEDS; i++)
                    begin
                        if (!found && (digit_left_reg[i] != 4'd0))
                        begin
                            found = 1'b1;
                            wr    = 1'b1;
                            if (!digit_on_reg[i])
                            begin
                                led              = lbps_pkg::LED_ALL_OFF & ~(4'd1 << i);
                                digit_on_next[i] = 1'b1;
                            end
                            else
                            begin
                                digit_on_next[i]   = 1'b0;
                                digit_left_next[i] = digit_left_reg[i] - 4'd1;
                            end
                        end
                    end
                end
                lbps_pkg::MODE_MARQUEE:
                begin
                    wr  = 1'b1;
                    led = lbps_pkg::LED_ALL_OFF & ~(4'd1 << mq_index_reg);
                    if (mq_fwd_reg)
                    begin
                        if (mq_index_reg == 2'd3)
                        begin
                            mq_index_next = 2'd2;
                            mq_fwd_next   = 1'b0;
                        end
                        else
                        begin
                            mq_index_next = mq_index_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        if (mq_index_reg == 2'd0)
                        begin
                            mq_index_next = 2'd1;
                            mq_fwd_next   = 1'b1;
                        end
                        else
                        begin
                            mq_index_next = mq_index_reg - 2'd1;
                        end
                    end
                end
                lbps_pkg::MODE_LOW:
                begin
                    if (low_left_reg != 8'd0)
                    begin
                        wr = 1'b1;
                        if (!low_on_reg)
                        begin
                            led         = lbps_pkg::LED_ALL_ON;
                            low_on_next = 1'b1;
                        end
                        else
                        begin
                            low_on_next   = 1'b0;
                            low_left_next = low_left_reg - 8'd1;
                        end
                    end
                end
                default:
                begin
                    stop = 1'b1;
                end
            endcase
        end
    end

    assign digits_done = (digit_left_next[0] == 4'd0) && (digit_left_next[1] == 4'd0) &&
                         (digit_left_next[2] == 4'd0) && (digit_left_next[3] == 4'd0);

    always_comb
    begin
        res.led_n      = wr ? led : 4'd0;
        res.led_write  = wr;
        res.timer_stop = stop;
        res.mode_now   = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= lbps_pkg::MODE_IDLE;
            clear_done_reg <= 2'd0;
            clear_on_reg   <= 1'b0;
            digit_on_reg   <= 4'd0;
            for (int i = 0; i < lbps_pkg::NUM_LEDS; i++)
            begin
                digit_left_reg[i] <= 4'd0;
            end
            mq_index_reg   <= 2'd0;
            mq_fwd_reg     <= 1'b1;
            low_on_reg     <= 1'b0;
            low_left_reg   <= 8'd0;
        end
        else if (fire)
        begin
            mode_reg       <= mode_next;
            clear_done_reg <= clear_done_next;
            clear_on_reg   <= clear_on_next;
            digit_on_reg   <= digit_on_next;
            digit_left_reg <= digit_left_next;
            mq_index_reg   <= mq_index_next;
            mq_fwd_reg     <= mq_fwd_next;
            low_on_reg     <= low_on_next;
            low_left_reg   <= low_left_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/lbps_out_reg.sv]
// ----------------------------------------------------------------------------
// lbps_out_reg
// Result register. Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lbps_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              res_valid,
    input  wire lbps_pkg::result_t res,
    output      logic              ready,
    output      logic              out_valid,
    input  wire logic              out_stall,
    output      lbps_pkg::result_t out_res
);

    logic              valid_reg;
    logic              valid_next;
    lbps_pkg::result_t res_reg;

    // A new beat can enter when the register is empty or is being emptied now.
    assign ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (ready)
        begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

[hw/rtl/led_blink_pattern_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// led_blink_pattern_sequencer_unit: four-LED start/tick blink sequencer.
// An input beat passes through the input register and then the result register to its result beat.
// Throughput: one beat per cycle while out_stall is low; the step update is a short combinational path.
// Reset (rst_n low) empties both registers and puts the sequencer in idle mode.
// ----------------------------------------------------------------------------
`default_nettype none

module led_blink_pattern_sequencer_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output      logic       in_stall,
    input  wire logic       func,
    input  wire logic [2:0] start_mode,
    input  wire logic [3:0] count_units,
    input  wire logic [3:0] count_tens,
    input  wire logic [3:0] count_hundreds,
    input  wire logic [3:0] count_thousands,
    input  wire logic [7:0] count_low,
    output      logic       out_valid,
    input  wire logic       out_stall,
    output      logic [3:0] led_n,
    output      logic       led_write,
    output      logic       timer_stop,
    output      logic [2:0] mode_now
);

    lbps_pkg::item_t   in_item;
    lbps_pkg::item_t   item;
    lbps_pkg::result_t res;
    lbps_pkg::result_t out_res;
    logic              item_valid;
    logic              out_ready;
    logic              fire;

    always_comb
    begin
        in_item.func            = func;
        in_item.start_mode      = start_mode;
        in_item.count_units     = count_units;
        in_item.count_tens      = count_tens;
        in_item.count_hundreds  = count_hundreds;
        in_item.count_thousands = count_thousands;
        in_item.count_low       = count_low;
    end

    assign fire = item_valid && out_ready;

    lbps_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    lbps_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item),
        .res   (res)
    );

    lbps_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (item_valid),
        .res       (res),
        .ready     (out_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign led_n      = out_res.led_n;
    assign led_write  = out_res.led_write;
    assign timer_stop = out_res.timer_stop;
    assign mode_now   = out_res.mode_now;

endmodule

`default_nettype wire
